@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the console cursor rtl
// expects clk_i and rst_ni in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds in the same cycle
`define ATCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition implies a result in the following cycle
`define ATCC_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (nxt)) \
    else $error(msg);

`endif

@@ hw/rtl/atcc_pkg.sv @@
// types and constants of the console cursor block
// no dependencies
`default_nettype none

package atcc_pkg;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_ESC  = 2'd1;
  localparam logic [1:0] MODE_CSI  = 2'd2;

  localparam logic [1:0] REG_COLUMNS     = 2'd0;
  localparam logic [1:0] REG_ROWS        = 2'd1;
  localparam logic [1:0] REG_SCROLL_ROWS = 2'd2;
  localparam logic [1:0] REG_MAX_GLYPH   = 2'd3;

  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_QUEST    = 8'h3F;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_M        = 8'h6D;
  localparam logic [7:0] CH_H        = 8'h48;
  localparam logic [7:0] FINAL_LO    = 8'h40;
  localparam logic [7:0] FINAL_HI    = 8'h7E;

  localparam logic [3:0] FORE_RESET = 4'hF;
  localparam logic [3:0] BACK_RESET = 4'h0;

  localparam logic [15:0] SGR_FG_LO  = 16'd30;
  localparam logic [15:0] SGR_FG_HI  = 16'd37;
  localparam logic [15:0] SGR_BG_LO  = 16'd40;
  localparam logic [15:0] SGR_BG_HI  = 16'd47;
  localparam logic [15:0] SGR_FGB_LO = 16'd90;
  localparam logic [15:0] SGR_FGB_HI = 16'd97;
  localparam logic [15:0] SGR_BGB_LO = 16'd100;
  localparam logic [15:0] SGR_BGB_HI = 16'd107;
  localparam logic [15:0] NUM_MAX    = 16'hFFFF;

  typedef struct packed {
    logic       busy;
    logic       full;
    logic       last_slot;
  } csi_stat_t;

  typedef struct packed {
    logic       fore_we;
    logic [3:0] fore;
    logic       back_we;
    logic [3:0] back;
    logic       cur_we;
    logic [7:0] row;
    logic [7:0] col;
  } csi_upd_t;

endpackage

`default_nettype wire

@@ hw/rtl/atcc_csi_engine.sv @@
// csi buffer and parameter walker: one buffered byte per cycle
// depends on atcc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module atcc_csi_engine import atcc_pkg::*; #(
  parameter int CSI_DEPTH = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       clear_i,
  input  wire logic       push_i,
  input  wire logic [7:0] byte_i,
  input  wire logic [7:0] rows_i,
  input  wire logic [7:0] columns_i,
  output csi_stat_t       stat_o,
  output csi_upd_t        upd_o
);

  localparam int IW = $clog2(CSI_DEPTH);
  localparam int CW = $clog2(CSI_DEPTH + 1);

  logic [7:0]    mem [CSI_DEPTH];
  logic [7:0]    rd_q;
  logic [IW-1:0] rd_addr;

  logic [CW-1:0] count_q, count_d;
  logic          walk_q, walk_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] nparam_q, nparam_d;
  logic          sgr_q, sgr_d;
  logic [15:0]   v_q, v_d;
  logic          seg_nz_q, seg_nz_d;
  logic          digits_q, digits_d;
  logic          zero_q, zero_d;
  logic [1:0]    p_q, p_d;
  logic [15:0]   cup0_q, cup0_d;
  logic [15:0]   cup1_q, cup1_d;

  logic          at_end, delim, is_dig, start;
  logic [19:0]   mac;
  logic [15:0]   v_sat;

  function automatic logic [7:0] cup_coord(input logic [15:0] v, input logic [7:0] lim);
    logic [15:0] c;
    logic [7:0]  top;
    c   = (v == 16'd0) ? 16'd0 : v - 16'd1;
    top = lim - 8'd1;
    if (lim == 8'd0) return 8'd0;
    if (c > {8'd0, top}) return top;
    return c[7:0];
  endfunction

  assign start   = push_i && ((byte_i == CH_M) || (byte_i == CH_H));
  assign at_end  = (idx_q == nparam_q);
  assign delim   = at_end || (rd_q == CH_SEMI);
  assign is_dig  = (rd_q >= CH_ZERO) && (rd_q <= CH_NINE);
  // v * 10 + digit
  assign mac     = {1'b0, v_q, 3'b000} + {3'b000, v_q, 1'b0} + {16'd0, rd_q[3:0]};
  assign v_sat   = (mac[19:16] != 4'd0) ? NUM_MAX : mac[15:0];
  assign rd_addr = !walk_q ? '0 :
                   (idx_q == IW'(CSI_DEPTH - 1)) ? '0 : idx_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[count_q[IW-1:0]] <= byte_i;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    count_d  = count_q;
    walk_d   = walk_q;
    idx_d    = idx_q;
    nparam_d = nparam_q;
    sgr_d    = sgr_q;
    v_d      = v_q;
    seg_nz_d = seg_nz_q;
    digits_d = digits_q;
    zero_d   = zero_q;
    p_d      = p_q;
    cup0_d   = cup0_q;
    cup1_d   = cup1_q;
    upd_o    = '0;

    if (clear_i) begin
      count_d = '0;
    end else if (push_i) begin
      count_d = count_q + 1'b1;
    end

    if (start) begin
      walk_d   = 1'b1;
      idx_d    = '0;
      nparam_d = count_q[IW-1:0];
      sgr_d    = (byte_i == CH_M);
      v_d      = '0;
      seg_nz_d = 1'b0;
      digits_d = 1'b1;
      zero_d   = 1'b0;
      p_d      = '0;
      cup0_d   = '0;
      cup1_d   = '0;
    end else if (walk_q) begin
      idx_d = idx_q + 1'b1;
      if (delim) begin
        v_d      = '0;
        seg_nz_d = 1'b0;
        digits_d = 1'b1;
        zero_d   = 1'b0;
        if (!sgr_q) begin
          if (p_q == 2'd0) cup0_d = v_q;
          if (p_q == 2'd1) cup1_d = v_q;
          if (p_q != 2'd2) p_d = p_q + 2'd1;
        end else if (!at_end || seg_nz_q || (nparam_q == '0)) begin
          if (!seg_nz_q || zero_q) begin
            upd_o.fore_we = 1'b1;
            upd_o.fore    = FORE_RESET;
            upd_o.back_we = 1'b1;
            upd_o.back    = BACK_RESET;
          end else if (v_q >= SGR_FG_LO && v_q <= SGR_FG_HI) begin
            upd_o.fore_we = 1'b1;
            upd_o.fore    = 4'(v_q - SGR_FG_LO);
          end else if (v_q >= SGR_BG_LO && v_q <= SGR_BG_HI) begin
            upd_o.back_we = 1'b1;
            upd_o.back    = 4'(v_q - SGR_BG_LO);
          end else if (v_q >= SGR_FGB_LO && v_q <= SGR_FGB_HI) begin
            upd_o.fore_we = 1'b1;
            upd_o.fore    = 4'(v_q - SGR_FGB_LO + 16'd8);
          end else if (v_q >= SGR_BGB_LO && v_q <= SGR_BGB_HI) begin
            upd_o.back_we = 1'b1;
            upd_o.back    = 4'(v_q - SGR_BGB_LO + 16'd8);
          end
        end
      end else begin
        if (digits_q && is_dig) begin
          v_d = v_sat;
        end else begin
          digits_d = 1'b0;
        end
        seg_nz_d = 1'b1;
        zero_d   = !seg_nz_q && (rd_q == CH_ZERO);
      end
      if (at_end) begin
        walk_d = 1'b0;
        if (!sgr_q) begin
          upd_o.cur_we = 1'b1;
          upd_o.row    = cup_coord(cup0_d, rows_i);
          upd_o.col    = cup_coord(cup1_d, columns_i);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      walk_q   <= 1'b0;
      idx_q    <= '0;
      nparam_q <= '0;
    end else begin
      count_q  <= count_d;
      walk_q   <= walk_d;
      idx_q    <= idx_d;
      nparam_q <= nparam_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sgr_q    <= sgr_d;
    v_q      <= v_d;
    seg_nz_q <= seg_nz_d;
    digits_q <= digits_d;
    zero_q   <= zero_d;
    p_q      <= p_d;
    cup0_q   <= cup0_d;
    cup1_q   <= cup1_d;
  end

  assign stat_o.busy      = walk_q;
  assign stat_o.full      = (count_q >= CW'(CSI_DEPTH));
  assign stat_o.last_slot = (count_q == CW'(CSI_DEPTH - 1));

  `ATCC_ASSERT(walk_idx_in_range, !walk_q || (idx_q <= nparam_q), "walk index past params")
  `ATCC_ASSERT_NEXT(walk_stops_at_end, walk_q && at_end, !walk_q, "walk did not stop")
  `ATCC_ASSERT(no_push_while_walking, !(push_i && walk_q), "byte pushed during walk")

endmodule

`default_nettype wire

@@ hw/rtl/ansi_text_console_cursor.sv @@
// console byte parser: cursor, colors, sgr/cup escapes, draw and scroll commands
// output: a result is offered from registers loaded as its byte is taken; a wrap scroll follows the draw
// input: plain bytes are taken while the output drains; after a wrap that scrolls, input waits for the draw
//   to be taken; a final m or H byte holds input while the csi walker reads one byte a cycle
// reset: asynchronous active low; idle mode, colors 15/0, cursor at 0,0, no output
// depends on atcc_pkg, atcc_csi_engine and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ansi_text_console_cursor import atcc_pkg::*; #(
  parameter int CSI_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [7:0]  s_tdata_i,   // byte_in
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [31:0]      m_tdata_o,   // glyph, cell_column, cell_row, fore_index, back_index
  output logic             m_tuser_o,   // kind
  output logic             m_tlast_o
);

  logic [7:0] columns_q, rows_q, scroll_rows_q, max_glyph_q;
  logic [1:0] mode_q, mode_d;
  logic [3:0] fore_q, fore_d, back_q, back_d;
  logic [7:0] col_q, col_d, row_q, row_d;
  logic       pend_q, pend_d;
  logic       out_valid_q, out_valid_d;
  logic       out_kind_q, out_kind_d, out_last_q, out_last_d;
  logic [7:0] out_glyph_q, out_glyph_d, out_col_q, out_col_d, out_row_q, out_row_d;
  logic [3:0] out_fore_q, out_fore_d, out_back_q, out_back_d;

  logic       acc, xfer, push, clear, is_final;
  logic [8:0] col_inc, row_inc;
  logic       wrap, scroll;
  logic [7:0] land, glyph;
  csi_stat_t  stat;
  csi_upd_t   upd;

  atcc_csi_engine #(.CSI_DEPTH(CSI_DEPTH)) u_csi (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (clear),
    .push_i    (push),
    .byte_i    (s_tdata_i),
    .rows_i    (rows_q),
    .columns_i (columns_q),
    .stat_o    (stat),
    .upd_o     (upd)
  );

  assign s_tready_o = !stat.busy && !pend_q && (!out_valid_q || m_tready_i);
  assign acc        = s_tvalid_i && s_tready_o;
  assign xfer       = out_valid_q && m_tready_i;
  assign push       = acc && (mode_q == MODE_CSI) && !stat.full;
  assign clear      = acc && (mode_q == MODE_ESC) && (s_tdata_i == CH_LBRACKET);
  assign is_final   = (s_tdata_i >= FINAL_LO) && (s_tdata_i <= FINAL_HI);

  assign col_inc = {1'b0, col_q} + 9'd1;
  assign row_inc = {1'b0, row_q} + 9'd1;
  assign wrap    = (col_inc >= {1'b0, columns_q});
  assign scroll  = (row_inc >= {1'b0, rows_q});
  assign land    = (scroll_rows_q < rows_q) ? rows_q - scroll_rows_q : 8'd0;
  assign glyph   = (s_tdata_i > max_glyph_q) ? CH_QUEST : s_tdata_i;

  always_comb begin
    mode_d      = mode_q;
    fore_d      = upd.fore_we ? upd.fore : fore_q;
    back_d      = upd.back_we ? upd.back : back_q;
    col_d       = upd.cur_we ? upd.col : col_q;
    row_d       = upd.cur_we ? upd.row : row_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    out_glyph_d = out_glyph_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    out_fore_d  = out_fore_q;
    out_back_d  = out_back_q;
    out_last_d  = out_last_q;

    if (xfer) begin
      out_valid_d = 1'b0;
      if (pend_q) begin
        // scroll that follows a wrapping draw
        out_valid_d = 1'b1;
        out_kind_d  = 1'b1;
        out_glyph_d = '0;
        out_col_d   = '0;
        out_row_d   = '0;
        out_last_d  = 1'b1;
        pend_d      = 1'b0;
      end
    end

    if (acc) begin
      unique case (mode_q)
        MODE_ESC: begin
          mode_d = (s_tdata_i == CH_LBRACKET) ? MODE_CSI : MODE_IDLE;
        end
        MODE_CSI: begin
          if (stat.full || is_final || stat.last_slot) mode_d = MODE_IDLE;
        end
        default: begin
          mode_d = MODE_IDLE;
          if (s_tdata_i == CH_ESC) begin
            mode_d = MODE_ESC;
          end else if (s_tdata_i == CH_LF) begin
            col_d = '0;
            if (scroll) begin
              row_d       = land;
              out_valid_d = 1'b1;
              out_kind_d  = 1'b1;
              out_glyph_d = '0;
              out_col_d   = '0;
              out_row_d   = '0;
              out_fore_d  = fore_q;
              out_back_d  = back_q;
              out_last_d  = 1'b1;
            end else begin
              row_d = row_inc[7:0];
            end
          end else begin
            out_valid_d = 1'b1;
            out_kind_d  = 1'b0;
            out_glyph_d = glyph;
            out_col_d   = col_q;
            out_row_d   = row_q;
            out_fore_d  = fore_q;
            out_back_d  = back_q;
            out_last_d  = 1'b1;
            if (wrap) begin
              col_d = '0;
              if (scroll) begin
                row_d      = land;
                pend_d     = 1'b1;
                out_last_d = 1'b0;
              end else begin
                row_d = row_inc[7:0];
              end
            end else begin
              col_d = col_inc[7:0];
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q     <= 8'd80;
      rows_q        <= 8'd25;
      scroll_rows_q <= 8'd1;
      max_glyph_q   <= 8'd127;
      mode_q        <= MODE_IDLE;
      fore_q        <= FORE_RESET;
      back_q        <= BACK_RESET;
      col_q         <= '0;
      row_q         <= '0;
      pend_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_COLUMNS:     columns_q     <= cfg_data_i;
          REG_ROWS:        rows_q        <= cfg_data_i;
          REG_SCROLL_ROWS: scroll_rows_q <= cfg_data_i;
          REG_MAX_GLYPH:   max_glyph_q   <= cfg_data_i;
          default:         max_glyph_q   <= max_glyph_q;
        endcase
      end
      mode_q      <= mode_d;
      fore_q      <= fore_d;
      back_q      <= back_d;
      col_q       <= col_d;
      row_q       <= row_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q  <= out_kind_d;
    out_glyph_q <= out_glyph_d;
    out_col_q   <= out_col_d;
    out_row_q   <= out_row_d;
    out_fore_q  <= out_fore_d;
    out_back_q  <= out_back_d;
    out_last_q  <= out_last_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {out_back_q, out_fore_q, out_row_q, out_col_q, out_glyph_q};
  assign m_tuser_o  = out_kind_q;
  assign m_tlast_o  = out_last_q;

  `ATCC_ASSERT(pend_behind_draw, !pend_q || (out_valid_q && !out_kind_q && !out_last_q),
               "pending scroll without a held draw")
  `ATCC_ASSERT(scroll_is_last, !(out_valid_q && out_kind_q) || out_last_q,
               "scroll transfer not marked last")
  `ATCC_ASSERT_NEXT(pend_follows_wrap, xfer && pend_q, out_valid_q && out_kind_q,
                    "scroll did not follow wrapping draw")

endmodule

`default_nettype wire

@@ tb/ansi_text_console_cursor_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the console cursor block: byte stream in, draw/scroll out
// depends on atcc_pkg and ansi_text_console_cursor; predicts every command and compares

module ansi_text_console_cursor_tb;
  import atcc_pkg::*;

  localparam int CSI_DEPTH = 16;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic       kind;
    logic [7:0] glyph;
    logic [7:0] col;
    logic [7:0] row;
    logic [3:0] fore;
    logic [3:0] back;
    logic       last;
  } console_cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = REG_COLUMNS;
  logic [7:0]  cfg_data_i = 8'h00;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [7:0]  s_tdata_i = 8'h00;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [31:0] m_tdata_o;
  logic        m_tuser_o;
  logic        m_tlast_o;

  ansi_text_console_cursor #(.CSI_DEPTH(CSI_DEPTH)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o),
    .m_tlast_o   (m_tlast_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // console model state
  logic [1:0]  parse_mode_q = MODE_IDLE;
  logic [7:0]  csi_buf [CSI_DEPTH];
  int          csi_len = 0;
  logic [3:0]  fore_q = FORE_RESET;
  logic [3:0]  back_q = BACK_RESET;
  logic [7:0]  cur_col = 8'd0;
  logic [7:0]  cur_row = 8'd0;
  logic [7:0]  cfg_columns = 8'd80;
  logic [7:0]  cfg_rows = 8'd25;
  logic [7:0]  cfg_scroll = 8'd1;
  logic [7:0]  cfg_max_glyph = 8'd127;

  console_cmd_t step_cmds [$];
  console_cmd_t expected_cmds [$];
  logic [7:0]   console_bytes [$];

  int bytes_sent = 0;
  int bytes_taken = 0;
  int draws_seen = 0;
  int scrolls_seen = 0;
  int failures = 0;
  int settings_used = 0;
  int quiet_cycles = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  logic s_fire = 1'b0;

  task automatic emit_cmd(input logic kind, input logic [7:0] glyph, input logic [7:0] col,
                          input logic [7:0] row);
    console_cmd_t c;
    c.kind = kind;
    c.glyph = glyph;
    c.col = col;
    c.row = row;
    c.fore = fore_q;
    c.back = back_q;
    c.last = 1'b0;
    step_cmds.push_back(c);
  endtask

  task automatic wrap_line();
    int next_row;
    next_row = cur_row + 1;
    cur_col = 8'd0;
    if (next_row >= cfg_rows) begin
      emit_cmd(1'b1, 8'd0, 8'd0, 8'd0);
      cur_row = (cfg_scroll < cfg_rows) ? cfg_rows - cfg_scroll : 8'd0;
    end else begin
      cur_row = next_row[7:0];
    end
  endtask

  task automatic set_colors(input bit empty, input bit zero_only, input int v);
    int d;
    if (empty || zero_only) begin
      fore_q = FORE_RESET;
      back_q = BACK_RESET;
    end else if (v >= SGR_FG_LO && v <= SGR_FG_HI) begin
      d = v - SGR_FG_LO;
      fore_q = d[3:0];
    end else if (v >= SGR_BG_LO && v <= SGR_BG_HI) begin
      d = v - SGR_BG_LO;
      back_q = d[3:0];
    end else if (v >= SGR_FGB_LO && v <= SGR_FGB_HI) begin
      d = v - SGR_FGB_LO + 8;
      fore_q = d[3:0];
    end else if (v >= SGR_BGB_LO && v <= SGR_BGB_HI) begin
      d = v - SGR_BGB_LO + 8;
      back_q = d[3:0];
    end
  endtask

  function automatic logic [7:0] clamp_coord(input int v, input logic [7:0] limit);
    int c;
    c = (v != 0) ? v - 1 : 0;
    if (limit == 8'd0) return 8'd0;
    if (c > limit - 1) c = limit - 1;
    return c[7:0];
  endfunction

  task automatic run_escape();
    int nparam;
    int seg_len;
    int p;
    int v;
    int cup_val [2];
    bit is_sgr;
    bit at_end;
    bit zero_only;
    bit digits;
    logic [7:0] fin;
    logic [7:0] c;
    nparam = csi_len - 1;
    fin = csi_buf[nparam];
    is_sgr = (fin == CH_M);
    if (!is_sgr && fin != CH_H) return;
    if (is_sgr && nparam == 0) begin
      set_colors(1'b1, 1'b0, 0);
      return;
    end
    v = 0;
    seg_len = 0;
    p = 0;
    digits = 1'b1;
    zero_only = 1'b0;
    cup_val[0] = 0;
    cup_val[1] = 0;
    for (int i = 0; i <= nparam; i++) begin
      at_end = (i == nparam);
      c = at_end ? 8'h00 : csi_buf[i];
      if (at_end || c == CH_SEMI) begin
        if (is_sgr) begin
          if (!at_end || seg_len != 0) set_colors(seg_len == 0, zero_only, v);
        end else begin
          if (p < 2) cup_val[p] = v;
          p++;
        end
        v = 0;
        seg_len = 0;
        digits = 1'b1;
        zero_only = 1'b0;
      end else begin
        if (digits && c >= CH_ZERO && c <= CH_NINE) begin
          v = v * 10 + (c - CH_ZERO);
          if (v > NUM_MAX) v = NUM_MAX;
        end else begin
          digits = 1'b0;
        end
        seg_len++;
        zero_only = (seg_len == 1 && c == CH_ZERO);
      end
    end
    if (!is_sgr) begin
      cur_row = clamp_coord(cup_val[0], cfg_rows);
      cur_col = clamp_coord(cup_val[1], cfg_columns);
    end
  endtask

  // advance the console by one byte and queue the commands it causes
  task automatic advance_console(input logic [7:0] b);
    console_cmd_t c;
    step_cmds.delete();
    if (parse_mode_q == MODE_ESC) begin
      if (b == CH_LBRACKET) begin
        parse_mode_q = MODE_CSI;
        csi_len = 0;
      end else begin
        parse_mode_q = MODE_IDLE;
      end
    end else if (parse_mode_q == MODE_CSI) begin
      if (csi_len >= CSI_DEPTH) begin
        parse_mode_q = MODE_IDLE;
      end else begin
        csi_buf[csi_len] = b;
        csi_len++;
        if (b >= FINAL_LO && b <= FINAL_HI) begin
          run_escape();
          parse_mode_q = MODE_IDLE;
        end else if (csi_len == CSI_DEPTH) begin
          parse_mode_q = MODE_IDLE;
        end
      end
    end else begin
      parse_mode_q = MODE_IDLE;
      if (b == CH_ESC) begin
        parse_mode_q = MODE_ESC;
      end else if (b == CH_LF) begin
        wrap_line();
      end else begin
        emit_cmd(1'b0, (b > cfg_max_glyph) ? CH_QUEST : b, cur_col, cur_row);
        if (cur_col + 1 >= cfg_columns) wrap_line();
        else cur_col = cur_col + 8'd1;
      end
    end
    for (int i = 0; i < step_cmds.size(); i++) begin
      c = step_cmds[i];
      c.last = (i == step_cmds.size() - 1);
      expected_cmds.push_back(c);
    end
  endtask

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("ERROR: %s", msg);
  endtask

  task automatic check_cmd();
    console_cmd_t got;
    console_cmd_t want;
    got.kind = m_tuser_o;
    got.glyph = m_tdata_o[7:0];
    got.col = m_tdata_o[15:8];
    got.row = m_tdata_o[23:16];
    got.fore = m_tdata_o[27:24];
    got.back = m_tdata_o[31:28];
    got.last = m_tlast_o;
    if (got.kind) scrolls_seen++;
    else draws_seen++;
    if (expected_cmds.size() == 0) begin
      note_failure($sformatf("unexpected command kind %0d glyph %02h at %0t",
                             got.kind, got.glyph, $realtime));
    end else begin
      want = expected_cmds.pop_front();
      if (got !== want) begin
        note_failure($sformatf({"command mismatch at %0t: expected kind %0d glyph %02h ",
                                "col %0d row %0d fg %0d bg %0d last %0d, got kind %0d ",
                                "glyph %02h col %0d row %0d fg %0d bg %0d last %0d"},
                               $realtime, want.kind, want.glyph, want.col, want.row,
                               want.fore, want.back, want.last, got.kind, got.glyph,
                               got.col, got.row, got.fore, got.back, got.last));
      end
    end
  endtask

  // transfer sampling, prediction, checking and watchdog
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_fire <= 1'b0;
      quiet_cycles = 0;
    end else begin
      s_fire <= s_tvalid_i && s_tready_o;
      if (s_tvalid_i && s_tready_o) begin
        bytes_taken++;
        advance_console(s_tdata_i);
      end
      if (m_tvalid_o && m_tready_i) check_cmd();
      if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("ansi_text_console_cursor_tb NOT OK");
        $finish;
      end
    end
  end

  // byte driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid_i <= 1'b0;
    end else if (!s_tvalid_i || s_fire) begin
      if (console_bytes.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        s_tvalid_i <= 1'b1;
        s_tdata_i <= console_bytes.pop_front();
      end else begin
        s_tvalid_i <= 1'b0;
      end
    end
  end

  // command receiver with random stalls and long hold-offs
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready_i <= 1'b0;
    end else if (hold_requests != holds_served) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic put_byte(input logic [7:0] b);
    console_bytes.push_back(b);
    bytes_sent++;
  endtask

  task automatic put_number(input int v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  function automatic logic [7:0] param_junk();
    return $urandom_range(1) ? 8'h20 + 8'($urandom_range(15)) : 8'h3C + 8'($urandom_range(3));
  endfunction

  function automatic logic [7:0] non_final_byte();
    return $urandom_range(1) ? 8'($urandom_range(63)) : 8'($urandom_range(255, 127));
  endfunction

  task automatic put_sgr();
    int nparam;
    nparam = $urandom_range(3);
    put_byte(CH_ESC);
    put_byte(CH_LBRACKET);
    for (int i = 0; i < nparam; i++) begin
      if (i != 0) put_byte(CH_SEMI);
      case ($urandom_range(8))
        0: ;
        1: put_byte(CH_ZERO);
        2: begin
          put_byte(CH_ZERO);
          put_byte(CH_ZERO);
        end
        3: put_number($urandom_range(37, 30));
        4: put_number($urandom_range(47, 40));
        5: put_number($urandom_range(97, 90));
        6: put_number($urandom_range(107, 100));
        7: begin
          put_number($urandom_range(120));
          if ($urandom_range(1)) put_byte(param_junk());
        end
        default: put_number($urandom_range(99999, 60000));
      endcase
    end
    if ($urandom_range(4) == 0) put_byte(CH_SEMI);
    put_byte(CH_M);
  endtask

  task automatic put_coord();
    case ($urandom_range(5))
      0: ;
      1: put_number($urandom_range(99999, 256));
      2: put_number(0);
      default: put_number($urandom_range(260));
    endcase
  endtask

  task automatic put_cup();
    int nparam;
    nparam = $urandom_range(3);
    put_byte(CH_ESC);
    put_byte(CH_LBRACKET);
    for (int i = 0; i < nparam; i++) begin
      if (i != 0) put_byte(CH_SEMI);
      put_coord();
    end
    put_byte(CH_H);
  endtask

  task automatic put_text_run();
    int n;
    logic [7:0] b;
    n = $urandom_range(8, 1);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(255));
      if ($urandom_range(9) == 0 || b == CH_ESC) b = CH_LF;
      put_byte(b);
    end
  endtask

  task automatic add_random_sequence();
    int sel;
    int n;
    logic [7:0] b;
    sel = $urandom_range(99);
    if (sel < 45) begin
      put_text_run();
    end else if (sel < 60) begin
      put_sgr();
    end else if (sel < 75) begin
      put_cup();
    end else if (sel < 80) begin
      put_byte(CH_ESC);
      put_byte(CH_LBRACKET);
      if ($urandom_range(1)) put_number($urandom_range(300));
      put_byte(FINAL_LO + 8'($urandom_range(62)));
    end else if (sel < 85) begin
      b = 8'($urandom_range(255));
      if (b == CH_LBRACKET) b = CH_ESC;
      put_byte(CH_ESC);
      put_byte(b);
    end else if (sel < 89) begin
      // buffer fill: short of full, exact fit, or overflow with the trailing bytes seen as text
      n = $urandom_range(17, 14);
      put_byte(CH_ESC);
      put_byte(CH_LBRACKET);
      for (int i = 0; i < n; i++) put_byte(non_final_byte());
      put_byte($urandom_range(1) ? CH_M : CH_H);
    end else begin
      put_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    case (index)
      REG_COLUMNS:     cfg_columns = value;
      REG_ROWS:        cfg_rows = value;
      REG_SCROLL_ROWS: cfg_scroll = value;
      default:         cfg_max_glyph = value;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (bytes_taken != bytes_sent || expected_cmds.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [7:0] cols, input logic [7:0] nrows,
                           input logic [7:0] scroll, input logic [7:0] max_glyph,
                           input int send_idle, input int recv_stall, input int items,
                           input bit hold);
    int start;
    wait_drained();
    write_reg(REG_COLUMNS, cols);
    write_reg(REG_ROWS, nrows);
    write_reg(REG_SCROLL_ROWS, scroll);
    write_reg(REG_MAX_GLYPH, max_glyph);
    settings_used++;
    @(posedge clk_i);
    sender_idle_pct = send_idle;
    recv_stall_pct = recv_stall;
    if (hold) hold_requests++;
    start = bytes_sent;
    while (bytes_sent - start < items) add_random_sequence();
  endtask

  initial begin
    int nrows;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: glyph extremes, newline, lone escape, color codes, cup to last cell
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(CH_LF);
    put_byte(CH_ESC);
    put_byte(8'h58);
    put_byte(CH_ESC);
    put_byte(CH_LBRACKET);
    put_number(97);
    put_byte(CH_SEMI);
    put_number(107);
    put_byte(CH_M);
    put_byte(CH_ESC);
    put_byte(CH_LBRACKET);
    put_byte(CH_M);
    put_byte(CH_ESC);
    put_byte(CH_LBRACKET);
    put_number(25);
    put_byte(CH_SEMI);
    put_number(80);
    put_byte(CH_H);
    put_byte(8'h5A);

    run_phase(8'd80, 8'd25, 8'd1, 8'd127, 0, 0, 305, 1'b1);
    run_phase(8'd1, 8'd2, 8'd1, 8'd0, 79, 0, 305, 1'b0);
    run_phase(8'd255, 8'd255, 8'd254, 8'd255, 0, 79, 305, 1'b0);
    run_phase(8'd10, 8'd5, 8'd4, 8'd64, 15, 15, 305, 1'b0);
    run_phase(8'd37, 8'd12, 8'd11, 8'd200, 0, 0, 305, 1'b1);
    nrows = $urandom_range(255, 2);
    run_phase(8'($urandom_range(255, 1)), 8'(nrows), 8'($urandom_range(nrows - 1, 1)),
              8'($urandom_range(255)), 15, 15, 305, 1'b0);
    wait_drained();

    $display("run covered %0d console bytes across %0d register settings,",
             bytes_taken, settings_used);
    $display("checking %0d draw and %0d scroll commands", draws_seen, scrolls_seen);
    if (failures == 0 && expected_cmds.size() == 0) begin
      $display("ansi_text_console_cursor_tb OK");
    end else begin
      $display("%0d mismatches, %0d commands never seen", failures, expected_cmds.size());
      $display("ansi_text_console_cursor_tb NOT OK");
    end
    $finish;
  end

endmodule
